// File: hdl/u8d_pkg.sv
// Shared types and constants for the six-byte UTF-8 sequence decoder.
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_LANES = 5;          // continuation bytes 1..5
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned VALUE_W  = 31;          // payload never exceeds 31 bits
    localparam int unsigned CP_W     = 32;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5    = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6    = 3'd6;

    localparam logic [CP_W-1:0] CP_ERROR = 32'hFFFF_FFFF;

    // lead byte decode result
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [6:0]       payload;     // raw low bits of the lead byte
    } lead_t;

    // one continuation lane result
    typedef struct packed {
        logic       ok;                // well formed, or outside the length
        logic [5:0] bits;              // six payload bits
    } lane_t;

endpackage

// File: hdl/utf8_sequence_decoder_top.sv
// Top level of the six-byte UTF-8 sequence decoder stream block.
//
// Decodes one code point per transfer from a six-byte window in the original
// six-byte UTF-8 form. The lead byte sets the length (1..6), five lanes check
// the continuation bytes side by side, and a merge stage assembles the value
// and rejects overlong forms. Invalid windows give code_point -1, byte_count 0
// and the valid flag low. Throughput is one window per clock while the receiver
// takes results; a window passes the lane register, then the output register.
// While a finished result waits on the receiver, the input stays ready only as
// long as the lane register is empty; with both registers full and the receiver
// stalled, s_axis_tready drops. Surrogates and values above 0x10FFFF pass.
module utf8_sequence_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // byte_0[7:0], byte_1 .. byte_5 (lowest first)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // code_point[31:0], byte_count[34:32], zero pad
    output logic        m_axis_tuser    // is_valid
);

    // ---- stage 0: lead decode and lanes (combinational) ----
    u8d_pkg::lead_t                            lead_c;
    u8d_pkg::lane_t [u8d_pkg::NUM_LANES-1:0]   lanes_c;

    u8d_lead u_lead (
        .lead_byte (s_axis_tdata[7:0]),
        .lead      (lead_c)
    );

    for (genvar i = 0; i < u8d_pkg::NUM_LANES; i++)
    begin : g_lane
        u8d_lane u_lane (
            .cont_byte (s_axis_tdata[8*(i+1) +: 8]),
            .in_seq    (lead_c.len > 3'(i + 1)),
            .lane      (lanes_c[i])
        );
    end

    // ---- stage 1: lane register ----
    logic                                      s1_valid_reg, s1_valid_next;
    u8d_pkg::lead_t                            s1_lead_reg;
    u8d_pkg::lane_t [u8d_pkg::NUM_LANES-1:0]   s1_lanes_reg;
    logic                                      out_free;
    logic                                      s1_free;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s1_free       = !s1_valid_reg || out_free;
    assign s_axis_tready = s1_free;
    assign s1_valid_next = s1_free ? s_axis_tvalid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && s_axis_tvalid)
        begin
            s1_lead_reg  <= lead_c;
            s1_lanes_reg <= lanes_c;
        end
    end

    // ---- stage 2: merge and output register ----
    logic [u8d_pkg::CP_W-1:0]  cp_c;
    logic [u8d_pkg::LEN_W-1:0] cnt_c;
    logic                      ok_c;

    u8d_merge u_merge (
        .lead       (s1_lead_reg),
        .lanes      (s1_lanes_reg),
        .code_point (cp_c),
        .byte_count (cnt_c),
        .is_valid   (ok_c)
    );

    logic                      m_valid_reg, m_valid_next;
    logic [u8d_pkg::CP_W-1:0]  m_cp_reg;
    logic [u8d_pkg::LEN_W-1:0] m_cnt_reg;
    logic                      m_ok_reg;

    assign m_valid_next = out_free ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            m_cp_reg  <= cp_c;
            m_cnt_reg <= cnt_c;
            m_ok_reg  <= ok_c;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_cnt_reg, m_cp_reg};
    assign m_axis_tuser  = m_ok_reg;

    // ---- assertions ----
    // a valid result always carries a nonzero length and a non-negative value
    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[34:32] != u8d_pkg::LEN_NONE && !m_axis_tdata[31]))
        else $error("valid result with zero length or negative code point");

    // an error result is all ones with zero length
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[31:0] == u8d_pkg::CP_ERROR
             && m_axis_tdata[34:32] == u8d_pkg::LEN_NONE))
        else $error("error result not in canonical form");

    // lane register holds while the output stage is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_lead_reg)
                                         && $stable(s1_lanes_reg)))
        else $error("lane register changed while stalled");

endmodule

// File: hdl/u8d_lead.sv
// Lead byte decoder: sequence length and raw payload bits.
module u8d_lead (
    input  logic [u8d_pkg::BYTE_W-1:0] lead_byte,
    output u8d_pkg::lead_t             lead
);

    always_comb
    begin
        lead.payload = lead_byte[6:0];
        if (lead_byte < 8'h80)
            lead.len = u8d_pkg::LEN_1;
        else if (lead_byte < 8'hC0)
            lead.len = u8d_pkg::LEN_NONE;  // continuation byte as lead
        else if (lead_byte < 8'hE0)
            lead.len = u8d_pkg::LEN_2;
        else if (lead_byte < 8'hF0)
            lead.len = u8d_pkg::LEN_3;
        else if (lead_byte < 8'hF8)
            lead.len = u8d_pkg::LEN_4;
        else if (lead_byte < 8'hFC)
            lead.len = u8d_pkg::LEN_5;
        else if (lead_byte < 8'hFE)
            lead.len = u8d_pkg::LEN_6;
        else
            lead.len = u8d_pkg::LEN_NONE;
    end

endmodule

// File: hdl/u8d_lane.sv
// One continuation byte lane: 10xxxxxx check when inside the sequence length.
module u8d_lane (
    input  logic [u8d_pkg::BYTE_W-1:0] cont_byte,
    input  logic                       in_seq,
    output u8d_pkg::lane_t             lane
);

    assign lane.ok   = !in_seq || (cont_byte[7:6] == 2'b10);
    assign lane.bits = cont_byte[5:0];

endmodule

// File: hdl/u8d_merge.sv
// Merge stage: assembles the code point and rejects bad or overlong forms.
module u8d_merge (
    input  u8d_pkg::lead_t                   lead,
    input  u8d_pkg::lane_t [u8d_pkg::NUM_LANES-1:0] lanes,
    output logic [u8d_pkg::CP_W-1:0]         code_point,
    output logic [u8d_pkg::LEN_W-1:0]        byte_count,
    output logic                             is_valid
);

    logic [u8d_pkg::VALUE_W-1:0] value;
    logic [u8d_pkg::LEN_W-1:0]   min_len;
    logic                        lanes_ok;
    logic                        ok;

    always_comb
    begin
        lanes_ok = 1'b1;
        for (int i = 0; i < u8d_pkg::NUM_LANES; i++)
            lanes_ok = lanes_ok & lanes[i].ok;
    end

    always_comb
    begin
        unique case (lead.len)
            u8d_pkg::LEN_1: value = {24'd0, lead.payload};
            u8d_pkg::LEN_2: value = {20'd0, lead.payload[4:0], lanes[0].bits};
            u8d_pkg::LEN_3: value = {15'd0, lead.payload[3:0], lanes[0].bits,
                                     lanes[1].bits};
            u8d_pkg::LEN_4: value = {10'd0, lead.payload[2:0], lanes[0].bits,
                                     lanes[1].bits, lanes[2].bits};
            u8d_pkg::LEN_5: value = {5'd0, lead.payload[1:0], lanes[0].bits,
                                     lanes[1].bits, lanes[2].bits, lanes[3].bits};
            u8d_pkg::LEN_6: value = {lead.payload[0], lanes[0].bits, lanes[1].bits,
                                     lanes[2].bits, lanes[3].bits, lanes[4].bits};
            default:        value = '0;
        endcase
    end

    // shortest form that carries the value
    always_comb
    begin
        if (value <= 31'h0000_007F)
            min_len = u8d_pkg::LEN_1;
        else if (value <= 31'h0000_07FF)
            min_len = u8d_pkg::LEN_2;
        else if (value <= 31'h0000_FFFF)
            min_len = u8d_pkg::LEN_3;
        else if (value <= 31'h001F_FFFF)
            min_len = u8d_pkg::LEN_4;
        else if (value <= 31'h03FF_FFFF)
            min_len = u8d_pkg::LEN_5;
        else
            min_len = u8d_pkg::LEN_6;
    end

    assign ok         = (lead.len != u8d_pkg::LEN_NONE) && lanes_ok && (min_len == lead.len);
    assign code_point = ok ? {1'b0, value} : u8d_pkg::CP_ERROR;
    assign byte_count = ok ? lead.len : u8d_pkg::LEN_NONE;
    assign is_valid   = ok;

endmodule

// File: sim/utf8_sequence_decoder_top_tb.sv
// Self-checking stream testbench for the six-byte UTF-8 sequence decoder.
`timescale 1ns / 1ps

module utf8_sequence_decoder_top_tb;

    // Six-byte window, lead byte first: bytes[0] is the candidate lead.
    typedef logic [0:5][u8d_pkg::BYTE_W-1:0] window_t;

    // One decode result as the block presents it.
    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0]  code_point;
        logic [u8d_pkg::LEN_W-1:0] byte_count;
        logic                      is_valid;
    } decode_t;

    // Directed vector; when known is set, want is the hand-written answer,
    // otherwise the answer comes from decode_window().
    typedef struct packed {
        window_t bytes;
        logic    known;
        decode_t want;
    } vector_t;

    // How a random window is built.
    typedef enum int unsigned {
        GEN_WELL_FORMED,
        GEN_BAD_CONT,
        GEN_OVERLONG,
        GEN_NOISE
    } gen_kind_t;

    localparam decode_t BAD = '{u8d_pkg::CP_ERROR, u8d_pkg::LEN_NONE, 1'b0};

    localparam int unsigned NUM_DIRECTED = 26;
    localparam int unsigned NUM_RANDOM   = 700;
    // Long receiver hold-off in the no-idle phase, to back the block up.
    localparam int unsigned HOLD_START   = NUM_DIRECTED + 2 * NUM_RANDOM / 3 + 40;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam vector_t DIRECTED [NUM_DIRECTED] = '{
        // NUL lead is a plain one-byte sequence
        '{48'h00_00_00_00_00_00, 1'b1, '{32'h0000_0000, u8d_pkg::LEN_1, 1'b1}},
        // largest one-byte value, tail ignored
        '{48'h7F_FF_FF_FF_FF_FF, 1'b1, '{32'h0000_007F, u8d_pkg::LEN_1, 1'b1}},
        // tail past the length holds junk
        '{48'h41_C0_00_FF_80_3F, 1'b0, BAD},
        // continuation bytes as lead
        '{48'h80_80_80_80_80_80, 1'b1, BAD},
        '{48'hBF_BF_BF_BF_BF_BF, 1'b1, BAD},
        // leads that never start a sequence
        '{48'hFE_80_80_80_80_80, 1'b1, BAD},
        '{48'hFF_FF_FF_FF_FF_FF, 1'b1, BAD},
        // overlong two-byte NUL
        '{48'hC0_80_00_00_00_00, 1'b1, BAD},
        // NUL where a continuation must be
        '{48'hC2_00_00_00_00_00, 1'b1, BAD},
        '{48'hC2_80_00_00_00_00, 1'b1, '{32'h0000_0080, u8d_pkg::LEN_2, 1'b1}},
        '{48'hDF_BF_00_00_00_00, 1'b1, '{32'h0000_07FF, u8d_pkg::LEN_2, 1'b1}},
        '{48'hE0_A0_80_00_00_00, 1'b1, '{32'h0000_0800, u8d_pkg::LEN_3, 1'b1}},
        // surrogate passes
        '{48'hED_A0_80_00_00_00, 1'b0, BAD},
        '{48'hEF_BF_BF_00_00_00, 1'b1, '{32'h0000_FFFF, u8d_pkg::LEN_3, 1'b1}},
        // 11xxxxxx in the middle of a three-byte form
        '{48'hE2_C0_80_00_00_00, 1'b1, BAD},
        // overlong four-byte form
        '{48'hF0_80_80_80_00_00, 1'b1, BAD},
        '{48'hF0_90_80_80_00_00, 1'b1, '{32'h0001_0000, u8d_pkg::LEN_4, 1'b1}},
        // top of the Unicode range, then just above it
        '{48'hF4_8F_BF_BF_00_00, 1'b0, BAD},
        '{48'hF4_90_80_80_00_00, 1'b0, BAD},
        '{48'hF7_BF_BF_BF_00_00, 1'b1, '{32'h001F_FFFF, u8d_pkg::LEN_4, 1'b1}},
        '{48'hF8_88_80_80_80_00, 1'b1, '{32'h0020_0000, u8d_pkg::LEN_5, 1'b1}},
        '{48'hFB_BF_BF_BF_BF_00, 1'b1, '{32'h03FF_FFFF, u8d_pkg::LEN_5, 1'b1}},
        '{48'hFC_84_80_80_80_80, 1'b1, '{32'h0400_0000, u8d_pkg::LEN_6, 1'b1}},
        '{48'hFD_BF_BF_BF_BF_BF, 1'b1, '{32'h7FFF_FFFF, u8d_pkg::LEN_6, 1'b1}},
        // last continuation of a six-byte form broken
        '{48'hFC_84_80_80_80_7F, 1'b1, BAD},
        // overlong six-byte form
        '{48'hFC_83_BF_BF_BF_BF, 1'b1, BAD}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // byte_0 .. byte_5, lowest first
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // code_point[31:0], byte_count[34:32], zero pad
    logic        m_axis_tuser;    // is_valid

    decode_t     pending_decodes [$];
    int unsigned windows_sent   = 0;
    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 12;
    int unsigned recv_stall_pct = 83;

    utf8_sequence_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Expected decode of one window: length from the lead, continuation
    // check inside that length, 31-bit payload, overlong rejection.
    function automatic decode_t decode_window(input window_t b);
        logic [u8d_pkg::LEN_W-1:0]   n;
        logic [u8d_pkg::LEN_W-1:0]   shortest;
        logic [u8d_pkg::VALUE_W-1:0] acc;
        logic good;
        int unsigned k;
        decode_t r;
        if (b[0] < 8'h80)       n = u8d_pkg::LEN_1;
        else if (b[0] < 8'hC0)  n = u8d_pkg::LEN_NONE;
        else if (b[0] < 8'hE0)  n = u8d_pkg::LEN_2;
        else if (b[0] < 8'hF0)  n = u8d_pkg::LEN_3;
        else if (b[0] < 8'hF8)  n = u8d_pkg::LEN_4;
        else if (b[0] < 8'hFC)  n = u8d_pkg::LEN_5;
        else if (b[0] < 8'hFE)  n = u8d_pkg::LEN_6;
        else                    n = u8d_pkg::LEN_NONE;
        good = (n != u8d_pkg::LEN_NONE);
        for (k = 1; k < n; k++)
            if (b[k][7:6] != 2'b10)
                good = 1'b0;
        acc = '0;
        if (good)
        begin
            // lead keeps 7 bits for one byte, 7-n bits otherwise
            acc = u8d_pkg::VALUE_W'(b[0] & (8'hFF >> ((n == u8d_pkg::LEN_1) ? 1 : n + 1)));
            for (k = 1; k < n; k++)
                acc = {acc[u8d_pkg::VALUE_W-7:0], b[k][5:0]};
            if (acc <= 31'h0000_007F)       shortest = u8d_pkg::LEN_1;
            else if (acc <= 31'h0000_07FF)  shortest = u8d_pkg::LEN_2;
            else if (acc <= 31'h0000_FFFF)  shortest = u8d_pkg::LEN_3;
            else if (acc <= 31'h001F_FFFF)  shortest = u8d_pkg::LEN_4;
            else if (acc <= 31'h03FF_FFFF)  shortest = u8d_pkg::LEN_5;
            else                            shortest = u8d_pkg::LEN_6;
            good = (shortest == n);
        end
        if (good)
            r = '{{1'b0, acc}, n, 1'b1};
        else
            r = BAD;
        return r;
    endfunction

    // Present one window, optionally after idle cycles, and log its decode
    // once the transfer happens.
    task automatic offer_window(input window_t b, input decode_t want);
        logic [47:0] packed_bytes;
        int unsigned k;
        for (k = 0; k < 6; k++)
            packed_bytes[8*k +: 8] = b[k];
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= packed_bytes;
        do @(posedge clk); while (!s_axis_tready);
        pending_decodes.push_back(want);
        windows_sent++;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: random stalls per phase, plus one long hold-off while the
    // sender keeps going so the pipeline fills and drops s_axis_tready.
    initial
    begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && windows_sent >= HOLD_START)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output checker: every transfer is matched against the oldest
    // outstanding decode, field by field.
    always @(posedge clk)
    begin
        decode_t got;
        decode_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tuser};
            if (pending_decodes.size() == 0)
            begin
                $error("unexpected result: code_point %h byte_count %0d is_valid %0b",
                       got.code_point, got.byte_count, got.is_valid);
                mismatches++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got.code_point !== want.code_point)
                begin
                    $error("code_point: expected %h, got %h", want.code_point,
                           got.code_point);
                    mismatches++;
                end
                if (got.byte_count !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d", want.byte_count,
                           got.byte_count);
                    mismatches++;
                end
                if (got.is_valid !== want.is_valid)
                begin
                    $error("is_valid: expected %0b, got %0b", want.is_valid,
                           got.is_valid);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed table, then random windows in three idle phases.
    initial
    begin
        window_t                     b;
        gen_kind_t                   kind;
        logic [u8d_pkg::VALUE_W-1:0] value;
        logic [1:0]                  top;
        int unsigned                 i, k, pick, seq_len, lo, hi;

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
            offer_window(DIRECTED[i].bytes,
                         DIRECTED[i].known ? DIRECTED[i].want
                                           : decode_window(DIRECTED[i].bytes));

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 3)
            begin
                send_idle_pct  = 83;
                recv_stall_pct = 12;
            end
            else if (i == 2 * NUM_RANDOM / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            pick = $urandom_range(99);
            if (pick < 60)       kind = GEN_WELL_FORMED;
            else if (pick < 75)  kind = GEN_BAD_CONT;
            else if (pick < 85)  kind = GEN_OVERLONG;
            else                 kind = GEN_NOISE;

            // random fill covers the tail past the length and pure noise
            for (k = 0; k < 6; k++)
                b[k] = 8'($urandom_range(255));

            if (kind != GEN_NOISE)
            begin
                seq_len = (kind == GEN_WELL_FORMED) ? $urandom_range(6, 1)
                                                    : $urandom_range(6, 2);
                case (seq_len)
                    1:       begin lo = 32'h0000_0000; hi = 32'h0000_007F; end
                    2:       begin lo = 32'h0000_0080; hi = 32'h0000_07FF; end
                    3:       begin lo = 32'h0000_0800; hi = 32'h0000_FFFF; end
                    4:       begin lo = 32'h0001_0000; hi = 32'h001F_FFFF; end
                    5:       begin lo = 32'h0020_0000; hi = 32'h03FF_FFFF; end
                    default: begin lo = 32'h0400_0000; hi = 32'h7FFF_FFFF; end
                endcase
                // overlong: a value that fits a shorter form
                value = (kind == GEN_OVERLONG)
                        ? u8d_pkg::VALUE_W'($urandom_range(lo - 1, 0))
                        : u8d_pkg::VALUE_W'($urandom_range(hi, lo));
                for (k = seq_len - 1; k >= 1; k--)
                begin
                    b[k]  = {2'b10, value[5:0]};
                    value = value >> 6;
                end
                if (seq_len == 1)
                    b[0] = value[7:0];
                else
                    b[0] = (8'hFF << (8 - seq_len)) | value[7:0];
                if (kind == GEN_BAD_CONT)
                begin
                    // any top pair but 10, NUL included
                    top = 2'($urandom_range(2));
                    if (top == 2'b10)
                        top = 2'b11;
                    k = $urandom_range(seq_len - 1, 1);
                    b[k][7:6] = top;
                end
            end
            offer_window(b, decode_window(b));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_decodes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("utf8_sequence_decoder_top_tb: PASS");
        else
            $display("utf8_sequence_decoder_top_tb: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("utf8_sequence_decoder_top_tb: FAIL");
        $finish;
    end

endmodule
